FILE: hdl/rcmg_pkg.sv
// ----------------------------------------------------------------------------
// rcmg_pkg
// shared constants, types and helpers of the relation constrained generator
// ----------------------------------------------------------------------------
package rcmg_pkg;

  localparam int MSG_WORDS   = 16;
  localparam int WORD_BITS   = 32;
  localparam int SCHED_WORDS = 80;
  localparam int REL_WORDS   = 17;
  localparam int PIVOTS      = MSG_WORDS * WORD_BITS;
  localparam int REL_DEPTH   = PIVOTS * REL_WORDS;

  localparam int REL_AW   = $clog2(REL_DEPTH);
  localparam int PIV_AW   = $clog2(PIVOTS);
  localparam int SCHED_AW = $clog2(SCHED_WORDS);

  localparam logic       REQ_LOAD = 1'b0;
  localparam logic       REQ_GEN  = 1'b1;

  localparam logic [4:0] REL_CONST_IDX = 5'd16;
  localparam logic [3:0] FIRST_EXP_T   = 4'd13;
  localparam logic [3:0] LAST_MSG_T    = 4'd15;
  localparam logic [4:0] LAST_BIT      = 5'd31;
  localparam logic [6:0] LAST_WORD     = 7'd79;
  localparam logic [6:0] EXP_LEAD      = 7'd3;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MARK  = 10'b0000000100,
    S_MARKW = 10'b0000001000,
    S_REL   = 10'b0000010000,
    S_RELW  = 10'b0000100000,
    S_WORD  = 10'b0001000000,
    S_EXP   = 10'b0010000000,
    S_EXPW  = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  // schedule taps of the expansion, one per read step
  function automatic logic [6:0] tap_offset(input logic [1:0] k);
    logic [6:0] r;
    case (k)
      2'd0:    r = 7'd3;
      2'd1:    r = 7'd8;
      2'd2:    r = 7'd14;
      default: r = 7'd16;
    endcase
    return r;
  endfunction

  // relation word address: pivot * 17 + index
  function automatic logic [REL_AW-1:0] rel_addr(input logic [PIV_AW-1:0] pidx,
                                                 input logic [4:0] idx);
    logic [REL_AW-1:0] p;
    p = REL_AW'(pidx);
    return (p << 4) + p + REL_AW'(idx);
  endfunction

endpackage

FILE: hdl/rcmg_ram.sv
// ----------------------------------------------------------------------------
// rcmg_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rcmg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/relation_constrained_message_generator.sv
// ----------------------------------------------------------------------------
// relation_constrained_message_generator
// builds message words under linear bit relations and emits the schedule
// ----------------------------------------------------------------------------
// A load request is taken in the idle state and returns nothing. A generate
// request for message word t walks the 32 pivot bits of word t through one
// sequencer: each bit has its present mark read, and a present pivot adds
// relation reads (one relation word and one earlier message word per cycle
// from single read ports). The new word is then emitted, and each schedule
// expansion word takes four tap reads from the schedule memory, a fold and
// the emit. A generate emits E = 0, 1 or 62 expansion words, and the result
// side can stall it. After reset a clearing pass resets the 512 present
// marks before the first request is taken.
// ----------------------------------------------------------------------------
module relation_constrained_message_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [3:0]  pivot_word,
  input  logic [4:0]  pivot_bit,
  input  logic [4:0]  rel_index,
  input  logic [31:0] rel_value,
  input  logic        entry_present,
  input  logic [31:0] random_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  word_index,
  output logic [31:0] word_value,
  output logic        last
);

  import rcmg_pkg::*;

  state_t              state;
  logic [3:0]          cnt;
  logic [PIV_AW-1:0]   clr_cnt;
  logic [4:0]          b;
  logic [4:0]          j;
  logic [4:0]          jd;
  logic                iss_v;
  logic                ev;
  logic                acc;
  logic [31:0]         mask;
  logic [31:0]         forced;
  logic [31:0]         rnd;
  logic [6:0]          i;
  logic [1:0]          k;
  logic [31:0]         x;

  logic                in_acc;
  logic                emit_ok;
  logic                emit_fire;
  logic                acc_next;
  logic [31:0]         mask_next;
  logic [31:0]         word_new;
  logic [31:0]         exp_word;
  logic [31:0]         emit_value;
  logic [6:0]          emit_index;
  logic                emit_last;
  logic [4:0]          iss_idx;

  logic                rel_we;
  logic [REL_AW-1:0]   rel_waddr;
  logic [REL_AW-1:0]   rel_raddr;
  logic [31:0]         rel_rdata;
  logic                mark_we;
  logic [PIV_AW-1:0]   mark_waddr;
  logic [0:0]          mark_wdata;
  logic [0:0]          mark_rdata;
  logic                sched_we;
  logic [SCHED_AW-1:0] sched_waddr;
  logic [SCHED_AW-1:0] sched_raddr;
  logic [31:0]         sched_rdata;

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign emit_ok   = !out_valid || out_ready;
  assign emit_fire = ((state == S_WORD) || (state == S_EMIT)) && emit_ok;

  assign iss_idx = (j <= {1'b0, cnt}) ? j : REL_CONST_IDX;

  // fold of one relation word read
  always_comb begin
    acc_next  = acc;
    mask_next = mask;
    if (state == S_MARKW) begin
      acc_next = 1'b0;
    end
    if (state == S_IDLE) begin
      mask_next = '0;
    end
    if (iss_v) begin
      if (jd < {1'b0, cnt}) begin
        acc_next = acc ^ (^(sched_rdata & rel_rdata));
      end else if (jd == {1'b0, cnt}) begin
        mask_next = mask | rel_rdata;
      end else begin
        acc_next = acc ^ rel_rdata[0];
      end
    end
  end

  assign word_new   = (rnd & ~mask) | forced;
  assign exp_word   = {x[30:0], x[31]};
  assign emit_value = (state == S_WORD) ? word_new : exp_word;
  assign emit_index = (state == S_WORD) ? {3'b000, cnt} : i;
  assign emit_last  = (state == S_WORD) ? (cnt < FIRST_EXP_T)
                                        : ((cnt != LAST_MSG_T) || (i == LAST_WORD));

  assign rel_we    = in_acc && (req_type == REQ_LOAD) && (rel_index <= REL_CONST_IDX);
  assign rel_waddr = rel_addr({pivot_word, pivot_bit}, rel_index);
  assign rel_raddr = rel_addr({cnt, b}, iss_idx);

  assign mark_we    = (state == S_CLEAR) || (in_acc && (req_type == REQ_LOAD));
  assign mark_waddr = (state == S_CLEAR) ? clr_cnt : {pivot_word, pivot_bit};
  assign mark_wdata = (state == S_CLEAR) ? 1'b0 : entry_present;

  assign sched_we    = emit_fire;
  assign sched_waddr = emit_index;
  assign sched_raddr = (state == S_EXP) ? (i - tap_offset(k)) : {3'b000, j[3:0]};

  rcmg_ram #(.WIDTH(32), .DEPTH(REL_DEPTH)) u_rel_ram (
    .clk   (clk),
    .we    (rel_we),
    .waddr (rel_waddr),
    .wdata (rel_value),
    .raddr (rel_raddr),
    .rdata (rel_rdata)
  );

  rcmg_ram #(.WIDTH(1), .DEPTH(PIVOTS)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr ({cnt, b}),
    .rdata (mark_rdata)
  );

  rcmg_ram #(.WIDTH(32), .DEPTH(SCHED_WORDS)) u_sched_ram (
    .clk   (clk),
    .we    (sched_we),
    .waddr (sched_waddr),
    .wdata (emit_value),
    .raddr (sched_raddr),
    .rdata (sched_rdata)
  );

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      iss_v     <= 1'b0;
      ev        <= 1'b0;
    end else begin
      iss_v <= (state == S_REL);
      ev    <= (state == S_EXP);
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == PIV_AW'(PIVOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && (req_type == REQ_GEN)) begin
            state <= S_MARK;
          end
        end
        S_MARK: begin
          state <= S_MARKW;
        end
        S_MARKW: begin
          if (mark_rdata[0]) begin
            state <= S_REL;
          end else if (b == LAST_BIT) begin
            state <= S_WORD;
          end else begin
            state <= S_MARK;
          end
        end
        S_REL: begin
          if (j == ({1'b0, cnt} + 5'd1)) begin
            state <= S_RELW;
          end
        end
        S_RELW: begin
          state <= (b == LAST_BIT) ? S_WORD : S_MARK;
        end
        S_WORD: begin
          if (emit_ok) begin
            if (cnt >= FIRST_EXP_T) begin
              state <= S_EXP;
            end else begin
              cnt   <= cnt + 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_EXP: begin
          if (k == 2'd3) begin
            state <= S_EXPW;
          end
        end
        S_EXPW: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_ok) begin
            if (emit_last) begin
              cnt   <= cnt + 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_EXP;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    acc  <= acc_next;
    mask <= mask_next;
    jd   <= j;
    if (ev) begin
      x <= x ^ sched_rdata;
    end
    if (emit_fire) begin
      word_index <= emit_index;
      word_value <= emit_value;
      last       <= emit_last;
    end
    case (state)
      S_IDLE: begin
        rnd    <= random_word;
        forced <= '0;
        b      <= '0;
      end
      S_MARKW: begin
        j <= '0;
        if (!mark_rdata[0]) begin
          b <= b + 1'b1;
        end
      end
      S_REL: begin
        j <= j + 1'b1;
      end
      S_RELW: begin
        forced[b] <= acc_next;
        b         <= b + 1'b1;
      end
      S_WORD: begin
        i <= {3'b000, cnt} + EXP_LEAD;
        k <= '0;
        x <= '0;
      end
      S_EXP: begin
        k <= k + 1'b1;
      end
      S_EMIT: begin
        if (emit_ok) begin
          i <= i + 1'b1;
          k <= '0;
          x <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hdl/rcmg_checker.sv
// ----------------------------------------------------------------------------
// rcmg_checker
// port level checks of the relation constrained generator, bound to the top
// ----------------------------------------------------------------------------
module rcmg_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        req_type,
  input  logic [3:0]  pivot_word,
  input  logic [4:0]  pivot_bit,
  input  logic [4:0]  rel_index,
  input  logic [31:0] rel_value,
  input  logic        entry_present,
  input  logic [31:0] random_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [6:0]  word_index,
  input  logic [31:0] word_value,
  input  logic        last
);

  import rcmg_pkg::*;

  // a generate request keeps the block busy
  a_gen_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type == REQ_GEN) |=> !in_ready)
    else $error("ready after generate request");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_index) && $stable(word_value)
      && $stable(last))
    else $error("stalled result changed");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (word_index <= LAST_WORD))
    else $error("schedule index out of range");

  // early message words and the final schedule word close their request
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((word_index < 7'(FIRST_EXP_T)) || (word_index == LAST_WORD)) |-> last)
    else $error("missing last mark");

endmodule

bind relation_constrained_message_generator rcmg_checker u_rcmg_checker (.*);

FILE: tb/relation_constrained_message_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relation_constrained_message_generator_test
// sends relation loads and generate requests with random handshake gaps and
// checks each emitted schedule word against a cycle-free prediction of the
// relation store, the constrained message words and the schedule expansion
// ----------------------------------------------------------------------------
module relation_constrained_message_generator_test;
  import rcmg_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_CYCLES  = 16;

  typedef struct {
    logic        kind;
    logic [3:0]  pword;
    logic [4:0]  pbit;
    logic [4:0]  rindex;
    logic [31:0] rvalue;
    logic        present;
    logic [31:0] rnd;
  } request_t;

  typedef struct {
    logic [6:0]  index;
    logic [31:0] value;
    logic        last;
  } sched_word_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic        req_type      = REQ_LOAD;
  logic [3:0]  pivot_word    = '0;
  logic [4:0]  pivot_bit     = '0;
  logic [4:0]  rel_index     = '0;
  logic [31:0] rel_value     = '0;
  logic        entry_present = 1'b0;
  logic [31:0] random_word   = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [6:0]  word_index;
  logic [31:0] word_value;
  logic        last;

  // predicted block state
  logic [31:0] rel_words [REL_DEPTH];
  bit   [16:0] rel_loaded [PIVOTS];
  bit          pivot_present [PIVOTS];
  logic [31:0] sched_words [SCHED_WORDS];
  bit   [3:0]  next_word = '0;

  sched_word_t expected_words [$];
  sched_word_t exp_word;

  int unsigned mismatch_count = 0;
  int unsigned requests_sent  = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 13;
  int unsigned recv_idle_pct  = 82;

  relation_constrained_message_generator i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .pivot_word    (pivot_word),
    .pivot_bit     (pivot_bit),
    .rel_index     (rel_index),
    .rel_value     (rel_value),
    .entry_present (entry_present),
    .random_word   (random_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .word_index    (word_index),
    .word_value    (word_value),
    .last          (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: word_index %0d word_value %h last %b",
                   word_index, word_value, last);
      end else begin
        exp_word = expected_words.pop_front();
        if (word_index !== exp_word.index)
          flag_mismatch("word_index", 32'(exp_word.index), 32'(word_index));
        if (word_value !== exp_word.value)
          flag_mismatch("word_value", exp_word.value, word_value);
        if (last !== exp_word.last)
          flag_mismatch("last", 32'(exp_word.last), 32'(last));
      end
    end
  end

  function automatic void push_word(input int i, input bit fin);
    sched_word_t w;
    w.index = 7'(i);
    w.value = sched_words[i];
    w.last  = fin;
    expected_words.push_back(w);
  endfunction

  function automatic void expand_word(input int i, input bit fin);
    logic [31:0] x;
    x = sched_words[i-3] ^ sched_words[i-8] ^ sched_words[i-14] ^ sched_words[i-16];
    sched_words[i] = {x[30:0], x[31]};
    push_word(i, fin);
  endfunction

  function automatic void predict_schedule(input request_t r);
    int pidx;
    int base;
    int t;
    logic [31:0] mask;
    logic [31:0] forced;
    logic [31:0] acc;
    if (r.kind == REQ_LOAD) begin
      pidx = int'(r.pword) * WORD_BITS + int'(r.pbit);
      if (r.rindex <= REL_CONST_IDX) begin
        rel_words[pidx * REL_WORDS + int'(r.rindex)] = r.rvalue;
        rel_loaded[pidx][r.rindex] = 1'b1;
      end
      pivot_present[pidx] = r.present;
    end else begin
      t      = int'(next_word);
      mask   = '0;
      forced = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
        pidx = t * WORD_BITS + b;
        if (pivot_present[pidx]) begin
          base = pidx * REL_WORDS;
          mask |= rel_words[base + t];
          acc = {31'b0, rel_words[base + MSG_WORDS][0]};
          for (int k = 0; k < t; k++)
            acc ^= sched_words[k] & rel_words[base + k];
          forced[b] = ^acc;
        end
      end
      sched_words[t] = (r.rnd & ~mask) | forced;
      push_word(t, t < int'(FIRST_EXP_T));
      if (t >= int'(FIRST_EXP_T))
        expand_word(t + int'(EXP_LEAD), t != int'(LAST_MSG_T));
      if (t == int'(LAST_MSG_T)) begin
        for (int i = int'(LAST_MSG_T) + int'(EXP_LEAD) + 1; i < SCHED_WORDS; i++)
          expand_word(i, i == int'(LAST_WORD));
      end
      next_word = 4'(t + 1);
    end
  endfunction

  function automatic request_t load_req(input logic [3:0] pw, input logic [4:0] pb,
                                        input logic [4:0] ri, input logic [31:0] v,
                                        input logic pres);
    request_t r;
    r.kind    = REQ_LOAD;
    r.pword   = pw;
    r.pbit    = pb;
    r.rindex  = ri;
    r.rvalue  = v;
    r.present = pres;
    r.rnd     = $urandom;
    return r;
  endfunction

  function automatic request_t gen_req(input logic [31:0] rnd);
    request_t r;
    r.kind    = REQ_GEN;
    r.pword   = 4'($urandom);
    r.pbit    = 5'($urandom);
    r.rindex  = 5'($urandom);
    r.rvalue  = $urandom;
    r.present = 1'($urandom);
    r.rnd     = rnd;
    return r;
  endfunction

  task automatic send_request(input request_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    req_type      <= r.kind;
    pivot_word    <= r.pword;
    pivot_bit     <= r.pbit;
    rel_index     <= r.rindex;
    rel_value     <= r.rvalue;
    entry_present <= r.present;
    random_word   <= r.rnd;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_schedule(r);
    requests_sent++;
  endtask

  // a present pivot of the next word must have all the words it reads loaded
  task automatic send_generate(input logic [31:0] rnd);
    int pidx;
    bit [16:0] need;
    need = '0;
    for (int k = 0; k <= int'(next_word); k++) need[k] = 1'b1;
    need[MSG_WORDS] = 1'b1;
    for (int b = 0; b < WORD_BITS; b++) begin
      pidx = int'(next_word) * WORD_BITS + b;
      if (pivot_present[pidx] && (rel_loaded[pidx] & need) != need)
        send_request(load_req(next_word, 5'(b), 5'($urandom_range(31, REL_WORDS)),
                              $urandom, 1'b0));
    end
    send_request(gen_req(rnd));
  endtask

  task automatic send_relation(input logic [3:0] pw, input logic [4:0] pb);
    for (int k = 0; k <= int'(pw); k++)
      send_request(load_req(pw, pb, 5'(k), $urandom, 1'($urandom)));
    send_request(load_req(pw, pb, REL_CONST_IDX, $urandom, 1'b1));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_relation_loads();
    // full mask with constant one forces bit 0 of word 0
    send_request(load_req(4'd0, 5'd0, 5'd0, 32'hFFFF_FFFF, 1'b1));
    send_request(load_req(4'd0, 5'd0, REL_CONST_IDX, 32'h0000_0001, 1'b1));
    // constant-only relation on the top bit of word 0
    send_request(load_req(4'd0, LAST_BIT, 5'd0, 32'h0000_0000, 1'b0));
    send_request(load_req(4'd0, LAST_BIT, REL_CONST_IDX, 32'hFFFF_FFFF, 1'b1));
    // forced bit outside the mask word
    send_request(load_req(4'd1, 5'd5, 5'd0, 32'hFFFF_FFFF, 1'b0));
    send_request(load_req(4'd1, 5'd5, 5'd1, 32'h0000_0000, 1'b0));
    send_request(load_req(4'd1, 5'd5, REL_CONST_IDX, 32'h0000_0000, 1'b1));
    // out of range index only moves the present mark
    send_request(load_req(4'd15, LAST_BIT, 5'd31, 32'hFFFF_FFFF, 1'b1));
    send_request(load_req(4'd15, LAST_BIT, 5'd17, 32'h0000_0000, 1'b0));
  endtask

  task automatic test_constrained_message();
    logic [31:0] patterns [4];
    patterns = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
    for (int t = 0; t < MSG_WORDS; t++)
      send_generate(t == int'(LAST_MSG_T) ? $urandom : patterns[t % 4]);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int unsigned send_pct,
                                     input int unsigned recv_pct,
                                     input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    logic [3:0] w;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_generate($urandom);
      end else if (pick < 75) begin
        w = next_word + 4'($urandom_range(2));
        send_relation(w, 5'($urandom));
      end else begin
        send_request(load_req(4'($urandom), 5'($urandom), 5'($urandom), $urandom,
                              1'($urandom_range(3) == 0)));
      end
    end
    wait_for_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_relation_loads();
    test_constrained_message();
    test_random_traffic(13, 82, 50);
    test_random_traffic(82, 13, 50);
    test_random_traffic(0, 0, 50);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
